### sv/tlvs_pkg.sv
// Package of shared types and constants for the TLV option store lookup block.
package tlvs_pkg;

  localparam int ADDR_W  = 10;
  localparam int TAG_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int HOP_W   = 9;
  localparam int MAX_HOP = 260;

  localparam logic [BYTE_W-1:0] ERASED_BYTE  = 8'hFF;
  localparam logic [HOP_W-1:0]  HEADER_BYTES = 9'd5;

  typedef enum logic [1:0] {
    OP_RAW_WRITE,
    OP_RAW_READ,
    OP_GET,
    OP_SET
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_OFFSET
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HDR,
    S_EVAL,
    S_ACCESS,
    S_RDWAIT,
    S_RESP
  } state_e;

endpackage

### sv/tlvs_ram.sv
// Generic single-port RAM with registered read data.
module tlvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tlv_option_store_lookup_core.sv
// Top level of the TLV option store: raw byte access and tag lookup with get and set.
//
// One input channel (in_valid_i / in_ready_o) takes an item with an operation,
// an address, a tag, an offset, a limit and a data byte. One output channel
// (out_valid_o / out_ready_i) returns exactly one result item for each input.
// The block handles one item at a time and is ready only between items.
// A raw write passes from the idle step through S_ACCESS to S_RESP, where the
// result register is loaded; a raw read also passes through S_RDWAIT.
// A get or set walks the record chain from address 0 through the single RAM
// port and one shared address adder: each record header takes 5 byte reads,
// one drain step and one evaluation, and a data access then passes through
// S_ACCESS and, for a get, S_RDWAIT before the result register is loaded.
// After reset the block sweeps the store to the erased value 0xFF, one byte
// per cycle, and it accepts no item until the sweep is done.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished result is held until the receiver takes the previous.
module tlv_option_store_lookup_core
  import tlvs_pkg::*;
#(
  parameter int STORE_BYTES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [ADDR_W-1:0]   store_address_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  logic [BYTE_W-1:0]   byte_offset_i,
  input  logic [BYTE_W-1:0]   copy_limit_i,
  input  logic [BYTE_W-1:0]   data_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [BYTE_W-1:0]   record_length_o,
  output logic [ADDR_W-1:0]   record_start_o,
  output logic [BYTE_W-1:0]   data_out_o
);

  localparam int AW      = $clog2(STORE_BYTES);
  localparam int PW_WALK = $clog2(STORE_BYTES + MAX_HOP + 1);
  localparam int PW      = (PW_WALK > ADDR_W) ? PW_WALK : ADDR_W;
  localparam logic [PW-1:0] END_ADDR  = PW'(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  state_e              state_q, state_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  logic                rd_oob_q;
  logic [TAG_W-1:0]    word_q, word_d;
  logic [BYTE_W-1:0]   len_q, len_d;
  op_e                 op_q, op_d;
  logic [TAG_W-1:0]    tag_q, tag_d;
  logic [BYTE_W-1:0]   offset_q, offset_d;
  logic [BYTE_W-1:0]   limit_q, limit_d;
  logic [BYTE_W-1:0]   din_q, din_d;
  status_e             res_status_q, res_status_d;
  logic [BYTE_W-1:0]   res_len_q, res_len_d;
  logic [ADDR_W-1:0]   res_start_q, res_start_d;
  logic [BYTE_W-1:0]   res_data_q, res_data_d;
  status_e             out_status_q;
  logic [BYTE_W-1:0]   out_len_q;
  logic [ADDR_W-1:0]   out_start_q;
  logic [BYTE_W-1:0]   out_data_q;

  logic [HOP_W-1:0]    addend;
  logic [PW-1:0]       sum;
  logic                sum_in;
  logic [BYTE_W-1:0]   rd_data;
  logic [BYTE_W-1:0]   ram_rdata;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                out_load;
  logic                in_range;
  logic                word_stop;
  logic                word_hit;
  logic                is_lookup;
  logic                is_read;

  assign is_lookup = (op_q == OP_GET) || (op_q == OP_SET);
  assign is_read   = (op_q == OP_RAW_READ) || (op_q == OP_GET);
  assign word_stop = (word_q == '0) || (word_q == '1);
  assign word_hit  = (word_q == tag_q);
  assign in_range  = (offset_q < limit_q) && (offset_q < len_q);

  always_comb begin
    unique case (state_q)
      S_HDR:    addend = HOP_W'(cnt_q);
      S_EVAL:   addend = word_hit ? HEADER_BYTES : HEADER_BYTES + HOP_W'(len_q);
      S_ACCESS: addend = is_lookup ? HOP_W'(offset_q) : '0;
      default:  addend = '0;
    endcase
  end

  assign sum     = pos_q + PW'(addend);
  assign sum_in  = (sum < END_ADDR);
  assign rd_data = rd_oob_q ? ERASED_BYTE : ram_rdata;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    word_d       = word_q;
    len_d        = len_q;
    op_d         = op_q;
    tag_d        = tag_q;
    offset_d     = offset_q;
    limit_d      = limit_q;
    din_d        = din_q;
    res_status_d = res_status_q;
    res_len_d    = res_len_q;
    res_start_d  = res_start_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(op_i);
          tag_d        = tag_i;
          offset_d     = byte_offset_i;
          limit_d      = copy_limit_i;
          din_d        = data_in_i;
          res_status_d = ST_OK;
          res_len_d    = '0;
          res_start_d  = '0;
          res_data_d   = '0;
          cnt_d        = '0;
          len_d        = '0;
          if ((op_e'(op_i) == OP_GET) || (op_e'(op_i) == OP_SET)) begin
            pos_d   = '0;
            state_d = S_HDR;
          end else begin
            pos_d   = PW'(store_address_i);
            state_d = S_ACCESS;
          end
        end
      end
      S_HDR: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(HEADER_BYTES)) begin
          len_d   = rd_data;
          cnt_d   = '0;
          state_d = S_EVAL;
        end else if (cnt_q != 3'd0) begin
          word_d = {word_q[TAG_W-BYTE_W-1:0], rd_data};
        end
      end
      S_EVAL: begin
        if (word_stop) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end else if (word_hit) begin
          pos_d       = sum;
          res_len_d   = len_q;
          res_start_d = ADDR_W'(sum);
          if (in_range) begin
            state_d = S_ACCESS;
          end else begin
            res_status_d = ST_OFFSET;
            state_d      = S_RESP;
          end
        end else if (sum_in) begin
          pos_d   = sum;
          state_d = S_HDR;
        end else begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end
      S_ACCESS: begin
        state_d = is_read ? S_RDWAIT : S_RESP;
      end
      S_RDWAIT: begin
        res_data_d = rd_data;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
    ram_we     = 1'b0;
    ram_addr   = sum[AW-1:0];
    ram_wdata  = din_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = ERASED_BYTE;
      end
      S_ACCESS: begin
        ram_we = !is_read && sum_in;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tlvs_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rd_oob_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      rd_oob_q    <= !sum_in;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    word_q       <= word_d;
    len_q        <= len_d;
    op_q         <= op_d;
    tag_q        <= tag_d;
    offset_q     <= offset_d;
    limit_q      <= limit_d;
    din_q        <= din_d;
    res_status_q <= res_status_d;
    res_len_q    <= res_len_d;
    res_start_q  <= res_start_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_len_q    <= res_len_q;
      out_start_q  <= res_start_q;
      out_data_q   <= res_data_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign record_length_o = out_len_q;
  assign record_start_o  = out_start_q;
  assign data_out_o      = out_data_q;

  a_walk_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HDR) |-> (pos_q < END_ADDR))
    else $error("Record walk left the store.");

  a_not_found_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_NOT_FOUND)) |->
      ((record_length_o == '0) && (record_start_o == '0) && (data_out_o == '0)))
    else $error("Missing record reported with nonzero fields.");

  a_offset_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_OFFSET)) |-> (data_out_o == '0))
    else $error("Out-of-range offset returned data.");

  a_result_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("Result item raised outside the response step.");

endmodule
